FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the homing sequencer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/mhs_pkg.sv
// ----------------------------------------------------------------------------
// mhs_pkg
// Types, register map and action codes of the motor homing sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mhs_pkg;

  // Action codes carried on the input tuser.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_STALL_ENABLE  = 3'd0;
  localparam logic [2:0] REG_STALL_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_STALL_MIN     = 3'd2;
  localparam logic [2:0] REG_DUTY_FLOOR    = 3'd3;
  localparam logic [2:0] REG_DUTY_CEILING  = 3'd4;
  localparam logic [2:0] REG_LOW_FITTED    = 3'd5;
  localparam logic [2:0] REG_HIGH_FITTED   = 3'd6;

  localparam logic [15:0] STALL_MIN_RESET    = 16'd4;
  localparam logic [7:0]  DUTY_FLOOR_RESET   = 8'd50;
  localparam logic [7:0]  DUTY_CEILING_RESET = 8'd255;
  localparam logic [30:0] TRAVEL_SAT         = 31'h7FFF_FFFF;

  typedef struct packed {
    logic        stall_enable;
    logic [31:0] stall_timeout_ms;
    logic [15:0] stall_min_counts;
    logic [7:0]  duty_floor;
    logic [7:0]  duty_ceiling;
    logic        low_switch_fitted;
    logic        high_switch_fitted;
  } mhs_cfg_t;

  typedef struct packed {
    logic        homing;
    logic        homed;
    logic        toward_low;
    logic [7:0]  latched_duty;
    logic [31:0] start_position;
    logic [30:0] travel_limit;
    logic        driving;
    logic [31:0] window_position;
    logic [31:0] window_time;
  } mhs_state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] position;
    logic [31:0] time_ms;
    logic        low_switch;
    logic        high_switch;
    logic [1:0]  direction;
    logic [7:0]  homing_duty;
    logic [31:0] travel_bound;
  } mhs_item_t;

  typedef struct packed {
    logic        zero_encoder;
    logic        accepted;
    logic        homed;
    logic        homing_active;
    logic        brake;
    logic [8:0]  drive;
  } mhs_result_t;

endpackage

FILE: hw/rtl/mhs_step.sv
// ----------------------------------------------------------------------------
// mhs_step
// Next-state and result logic for one word of the homing sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhs_step import mhs_pkg::*; (
  input  mhs_cfg_t    cfg,
  input  mhs_state_t  state,
  input  mhs_item_t   item,
  output mhs_state_t  state_next,
  output mhs_result_t result
);

  logic [32:0] win_diff;
  logic [32:0] win_mag;
  logic [32:0] trav_diff;
  logic [32:0] trav_mag;
  logic [31:0] elapsed;
  logic [31:0] tb_abs;
  logic [30:0] travel_sat;
  logic [7:0]  duty_lo;
  logic [7:0]  duty_clamped;
  logic        start_neg;
  logic        start_fitted;
  logic        tgt_fitted;
  logic        tgt_pressed;
  logic        reached;
  logic        moved;

  always_comb begin
    // Exact 33-bit differences against the stall window and the start point.
    win_diff  = {item.position[31], item.position}
              - {state.window_position[31], state.window_position};
    win_mag   = win_diff[32] ? (33'd0 - win_diff) : win_diff;
    trav_diff = {item.position[31], item.position}
              - {state.start_position[31], state.start_position};
    trav_mag  = trav_diff[32] ? (33'd0 - trav_diff) : trav_diff;
    elapsed   = item.time_ms - state.window_time;

    // Travel bound magnitude, with the most negative value saturating.
    tb_abs     = item.travel_bound[31] ? (32'd0 - item.travel_bound) : item.travel_bound;
    travel_sat = tb_abs[31] ? TRAVEL_SAT : tb_abs[30:0];

    duty_lo      = (cfg.duty_floor < cfg.duty_ceiling) ? cfg.duty_floor : cfg.duty_ceiling;
    duty_clamped = (item.homing_duty < duty_lo) ? duty_lo : item.homing_duty;
    if (duty_clamped > cfg.duty_ceiling) begin
      duty_clamped = cfg.duty_ceiling;
    end

    start_neg    = item.direction[1];
    start_fitted = start_neg ? cfg.low_switch_fitted : cfg.high_switch_fitted;
    tgt_fitted   = state.toward_low ? cfg.low_switch_fitted : cfg.high_switch_fitted;
    tgt_pressed  = state.toward_low ? item.low_switch : item.high_switch;
    moved        = win_mag >= {17'd0, cfg.stall_min_counts};

    state_next = state;
    result     = '0;
    reached    = 1'b0;

    case (item.action)
      ACT_START: begin
        if ((item.direction != 2'd0) && (start_fitted || cfg.stall_enable)) begin
          state_next.latched_duty   = duty_clamped;
          state_next.toward_low     = start_neg;
          state_next.travel_limit   = travel_sat;
          state_next.start_position = item.position;
          state_next.homed          = 1'b0;
          state_next.homing         = 1'b1;
          state_next.driving        = 1'b0;
          result.accepted           = 1'b1;
        end
      end
      ACT_STOP: begin
        state_next.homing  = 1'b0;
        state_next.driving = 1'b0;
        result.brake       = 1'b1;
      end
      ACT_TICK: begin
        if (state.homing) begin
          if (!tgt_fitted && !cfg.stall_enable) begin
            // No end detector is left for this direction.
            state_next.homing  = 1'b0;
            state_next.homed   = 1'b0;
            state_next.driving = 1'b0;
            result.brake       = 1'b1;
          end else begin
            reached = tgt_fitted && tgt_pressed;
            if (!reached && cfg.stall_enable && state.driving) begin
              if (moved) begin
                state_next.window_position = item.position;
                state_next.window_time     = item.time_ms;
              end else begin
                reached = elapsed >= cfg.stall_timeout_ms;
              end
            end
            if (reached) begin
              state_next.homing  = 1'b0;
              state_next.homed   = 1'b1;
              state_next.driving = 1'b0;
              result.brake        = 1'b1;
              result.zero_encoder = 1'b1;
            end else if ((state.travel_limit != 31'd0) &&
                         (trav_mag >= {2'd0, state.travel_limit})) begin
              state_next.homing  = 1'b0;
              state_next.homed   = 1'b0;
              state_next.driving = 1'b0;
              result.brake       = 1'b1;
            end else begin
              if (!state.driving) begin
                state_next.window_position = item.position;
                state_next.window_time     = item.time_ms;
              end
              state_next.driving = 1'b1;
              result.drive = state.toward_low ? (9'd0 - {1'b0, state.latched_duty})
                                              : {1'b0, state.latched_duty};
            end
          end
        end
      end
      default: begin
        // Unused action code: no state change and no pulses.
      end
    endcase

    result.homing_active = state_next.homing;
    result.homed         = state_next.homed;
  end

endmodule

FILE: hw/rtl/motor_homing_stall_sequencer.sv
// ----------------------------------------------------------------------------
// motor_homing_stall_sequencer
// Homing sequencer for a DC motor with limit-switch and stall end detection.
// ----------------------------------------------------------------------------
// Usage. Each input word on the s_ group is one control event: a tick, a
// start request or a stop request, selected by s_tuser. Every input word
// produces exactly one result word on the m_ group, in order, carrying the
// signed drive duty, the brake pulse, the homing and homed status and the
// start-accepted and zero-encoder pulses.
// A word passes the input register and then the result register before its
// result is valid. The block takes a new word in every cycle unless the result
// register is held by a stalled receiver; the throughput of one word per cycle
// is set by the homing state update between the input and result registers.
// The APB port holds the seven configuration registers and may only be
// written while no word is in flight.
// Reset (rst, synchronous) clears the homing state, empties both registers
// and loads the register defaults. If the receiver stalls, the result word is
// held on m_tdata, and the input register keeps its word until the result
// register frees up, so s_tready drops one word later.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_homing_stall_sequencer import mhs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // Input words.
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata from bit 0: position[31:0], time_ms[63:32], low_switch[64],
  // high_switch[65], direction[67:66], homing_duty[75:68],
  // travel_bound[107:76], zero pad[111:108].
  input  logic [111:0] s_tdata,
  // s_tuser: action[1:0] (tick, start, stop).
  input  logic [1:0]   s_tuser,
  // Result words.
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata from bit 0: drive[8:0], brake[9], homing_active[10], homed[11],
  // accepted[12], zero_encoder[13], zero pad[15:14].
  output logic [15:0]  m_tdata,
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  mhs_cfg_t    cfg;
  mhs_state_t  state;
  mhs_state_t  state_next;
  mhs_item_t   item;
  mhs_result_t result;
  logic        item_valid;
  logic        advance;
  logic        cfg_write;
  logic [2:0]  reg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[4:2];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stall_enable       <= 1'b0;
      cfg.stall_timeout_ms   <= 32'd0;
      cfg.stall_min_counts   <= STALL_MIN_RESET;
      cfg.duty_floor         <= DUTY_FLOOR_RESET;
      cfg.duty_ceiling       <= DUTY_CEILING_RESET;
      cfg.low_switch_fitted  <= 1'b0;
      cfg.high_switch_fitted <= 1'b0;
    end else if (cfg_write) begin
      case (reg_index)
        REG_STALL_ENABLE:  cfg.stall_enable       <= pwdata[0];
        REG_STALL_TIMEOUT: cfg.stall_timeout_ms   <= pwdata;
        REG_STALL_MIN:     cfg.stall_min_counts   <= pwdata[15:0];
        REG_DUTY_FLOOR:    cfg.duty_floor         <= pwdata[7:0];
        REG_DUTY_CEILING:  cfg.duty_ceiling       <= pwdata[7:0];
        REG_LOW_FITTED:    cfg.low_switch_fitted  <= pwdata[0];
        REG_HIGH_FITTED:   cfg.high_switch_fitted <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_STALL_ENABLE:  prdata = {31'd0, cfg.stall_enable};
      REG_STALL_TIMEOUT: prdata = cfg.stall_timeout_ms;
      REG_STALL_MIN:     prdata = {16'd0, cfg.stall_min_counts};
      REG_DUTY_FLOOR:    prdata = {24'd0, cfg.duty_floor};
      REG_DUTY_CEILING:  prdata = {24'd0, cfg.duty_ceiling};
      REG_LOW_FITTED:    prdata = {31'd0, cfg.low_switch_fitted};
      REG_HIGH_FITTED:   prdata = {31'd0, cfg.high_switch_fitted};
      default:           prdata = 32'd0;
    endcase
  end

  // The input register moves on whenever the result register is empty or
  // being drained, so a full pipe still takes a word every cycle.
  assign advance  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.action       <= s_tuser;
      item.position     <= s_tdata[31:0];
      item.time_ms      <= s_tdata[63:32];
      item.low_switch   <= s_tdata[64];
      item.high_switch  <= s_tdata[65];
      item.direction    <= s_tdata[67:66];
      item.homing_duty  <= s_tdata[75:68];
      item.travel_bound <= s_tdata[107:76];
    end
  end

  mhs_step u_step (
    .cfg        (cfg),
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .result     (result)
  );

  // The homing state commits exactly when the word's result is registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {2'b00, result};
    end
  end

endmodule

FILE: hw/rtl/mhs_checker.sv
// ----------------------------------------------------------------------------
// mhs_checker
// Port-level checks of the homing sequencer result stream, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mhs_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // A stalled result word stays offered and unchanged.
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `ASSERT_NEXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))
  // An accepted start leaves homing running and the homed flag cleared.
  `ASSERT_IMPL(a_accept_state, clk, rst, m_tvalid && m_tdata[12], m_tdata[10] && !m_tdata[11])
  // A zero-encoder request only comes with a braked, successful end.
  `ASSERT_IMPL(a_zero_end, clk, rst, m_tvalid && m_tdata[13],
    m_tdata[9] && m_tdata[11] && !m_tdata[10])
  // Drive is only issued while homing continues, never with a brake.
  `ASSERT_IMPL(a_drive_homing, clk, rst, m_tvalid && (m_tdata[8:0] != 9'd0),
    m_tdata[10] && !m_tdata[9])

endmodule

bind motor_homing_stall_sequencer mhs_checker u_mhs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
